// ===== hw/rtl/srcm_pkg.sv =====
package srcm_pkg;

  localparam int RunDepthDef  = 1024;
  localparam int RunCountDef  = 3;
  localparam int FileHdrBytes = 3 * 4;
  localparam int EntryOvhBytes = 2 * 4;
  localparam int SizeLimitRst = 256 * 1024;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  localparam logic [1:0] REG_RUN0_TIME  = 2'd0;
  localparam logic [1:0] REG_RUN1_TIME  = 2'd1;
  localparam logic [1:0] REG_RUN2_TIME  = 2'd2;
  localparam logic [1:0] REG_SIZE_LIMIT = 2'd3;

  typedef struct packed {
    logic               func;
    logic [1:0]         run_select;
    logic signed [31:0] entry_key;
    logic [18:0]        entry_length;
    logic [15:0]        entry_handle;
  } srcm_req_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] out_key;
    logic [18:0]        out_length;
    logic [15:0]        out_handle;
    logic [15:0]        file_number;
    logic [30:0]        value_offset;
    logic               end_of_file;
    logic [11:0]        file_entries;
    logic [30:0]        file_bytes;
    logic               done_res;
  } srcm_rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [18:0]        length;
    logic [15:0]        handle;
  } entry_t;

  typedef struct packed {
    logic        upd;
    logic        more;
    entry_t      cur;
    logic [18:0] nxt_len;
  } file_req_t;

endpackage

// ===== hw/rtl/srcm_mem.sv =====
module srcm_mem #(
  parameter int DEPTH = 3072
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr_i,
  input  srcm_pkg::entry_t                     wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr_i,
  output srcm_pkg::entry_t                     rd_data_o
);
  import srcm_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hw/rtl/srcm_file.sv =====
module srcm_file (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srcm_pkg::file_req_t req_i,
  input  logic [30:0]         size_limit_i,
  output srcm_pkg::srcm_rsp_t rsp_o
);
  import srcm_pkg::*;

  logic [15:0] file_num_q, file_num_d;
  logic [31:0] bytes_q, bytes_d;
  logic [11:0] ents_q, ents_d;
  logic [31:0] vbytes_q, vbytes_d;
  logic [31:0] bytes_new;
  logic [31:0] vbytes_new;
  logic [11:0] ents_new;
  logic [32:0] nxt_tot;
  logic        eof;

  always_comb begin
    bytes_new  = bytes_q + 32'(EntryOvhBytes) + 32'(req_i.cur.length);
    vbytes_new = vbytes_q + 32'(req_i.cur.length);
    ents_new   = ents_q + 12'd1;
    nxt_tot    = {1'b0, bytes_new} + 33'(EntryOvhBytes) + 33'(req_i.nxt_len);
    eof        = !req_i.more || (nxt_tot >= 33'(size_limit_i));

    rsp_o              = '0;
    rsp_o.valid_res    = 1'b1;
    rsp_o.out_key      = req_i.cur.key;
    rsp_o.out_length   = req_i.cur.length;
    rsp_o.out_handle   = req_i.cur.handle;
    rsp_o.file_number  = file_num_q;
    rsp_o.value_offset = vbytes_q[30:0];
    rsp_o.end_of_file  = eof;
    rsp_o.file_entries = eof ? ents_new : '0;
    rsp_o.file_bytes   = eof ? bytes_new[30:0] : '0;
    rsp_o.done_res     = !req_i.more;

    file_num_d = file_num_q;
    bytes_d    = bytes_q;
    ents_d     = ents_q;
    vbytes_d   = vbytes_q;
    if (req_i.upd) begin
      if (eof) begin
        file_num_d = file_num_q + 16'd1;
        bytes_d    = 32'(FileHdrBytes);
        ents_d     = '0;
        vbytes_d   = '0;
      end else begin
        bytes_d  = bytes_new;
        ents_d   = ents_new;
        vbytes_d = vbytes_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_num_q <= '0;
      bytes_q    <= 32'(FileHdrBytes);
      ents_q     <= '0;
      vbytes_q   <= '0;
    end else begin
      file_num_q <= file_num_d;
      bytes_q    <= bytes_d;
      ents_q     <= ents_d;
      vbytes_q   <= vbytes_d;
    end
  end

endmodule

// ===== hw/rtl/sorted_run_compaction_merge.sv =====
// Merge of up to three sorted runs into packed output files.
// Request channel (in_valid_i/in_ready_o, in_req_i): func 0 loads one entry into
// the run named by run_select; func 1 pulls the next surviving entry.
// Response channel (out_valid_o/out_ready_i, out_rsp_o): one response per pull,
// none per load. Loads beyond RUN_COUNT or into a full run are dropped.
// A load is written to the entry memory as it is taken. A pull steps through
// FILL, which checks the run heads and reads the entry memory to refill an empty
// one, WAIT, which loads the read entry into that head, PICK, which takes the
// smallest key, and EMIT, which registers the response. A key pick is a head
// check and the pick itself; a tombstone costs a pick, while heads that hold the
// winner's key are dropped in the same pick. Heads are refilled one at a time,
// as the entry memory has a single read port.
// Requests are taken only while no pull is in flight. A finished response sits
// in an output register; loads are still taken while it waits, and a pull
// stalls in its last step until the receiver frees the register.
// Reset clears run fill and cursor counts, file counters and the lookahead;
// the entry memory is not cleared, and only written entries are ever read.
// Registers over APB: run0_time, run1_time, run2_time, size_limit at 0/4/8/12.
module sorted_run_compaction_merge #(
  parameter int RUN_DEPTH = srcm_pkg::RunDepthDef,
  parameter int RUN_COUNT = srcm_pkg::RunCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srcm_pkg::srcm_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srcm_pkg::srcm_rsp_t out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import srcm_pkg::*;

  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam int MD = RUN_COUNT * RUN_DEPTH;
  localparam int AW = $clog2(MD);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [30:0] t0_q, t1_q, t2_q, limit_q;
  logic [CW-1:0] fill_q [RUN_COUNT];
  logic [CW-1:0] cursor_q [RUN_COUNT];
  logic [RUN_COUNT-1:0] head_vld_q;
  entry_t head_q [RUN_COUNT];
  logic [1:0]  rsel_q;
  logic        phase_q;
  logic        have_cur_q;
  logic        more_q;
  logic        la_vld_q;
  entry_t      cur_q;
  entry_t      la_q;
  logic        out_valid_q;
  srcm_rsp_t   out_q;

  logic        cfg_wr;
  logic        in_acc;
  logic        ld_ok;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  entry_t      wr_data;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  entry_t      rd_data;
  logic        fnd;
  logic [1:0]  fsel;
  logic        any;
  logic signed [31:0] kmin;
  logic [RUN_COUNT-1:0] eq;
  logic        wfnd;
  logic [1:0]  win;
  entry_t      win_e;
  logic        emit;
  file_req_t   freq;
  srcm_rsp_t   frsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_RUN0_TIME:  prdata = {1'b0, t0_q};
      REG_RUN1_TIME:  prdata = {1'b0, t1_q};
      REG_RUN2_TIME:  prdata = {1'b0, t2_q};
      REG_SIZE_LIMIT: prdata = {1'b0, limit_q};
      default:        prdata = '0;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    ld_ok = 1'b0;
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (in_req_i.run_select == 2'(r) && fill_q[r] < CW'(RUN_DEPTH)) begin
        ld_ok = 1'b1;
      end
    end
  end

  always_comb begin
    wr_en          = in_acc && (in_req_i.func == FUNC_LOAD) && ld_ok;
    wr_addr        = '0;
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (in_req_i.run_select == 2'(r)) begin
        wr_addr = AW'(r * RUN_DEPTH) + AW'(fill_q[r]);
      end
    end
    wr_data.key    = in_req_i.entry_key;
    wr_data.length = in_req_i.entry_length;
    wr_data.handle = in_req_i.entry_handle;
  end

  always_comb begin
    fnd  = 1'b0;
    fsel = '0;
    for (int r = RUN_COUNT - 1; r >= 0; r--) begin
      if (!head_vld_q[r] && cursor_q[r] < fill_q[r]) begin
        fnd  = 1'b1;
        fsel = 2'(r);
      end
    end
    rd_en   = (state_q == ST_FILL) && fnd;
    rd_addr = '0;
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (fsel == 2'(r)) begin
        rd_addr = AW'(r * RUN_DEPTH) + AW'(cursor_q[r]);
      end
    end
  end

  always_comb begin
    any  = 1'b0;
    kmin = '0;
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (head_vld_q[r] && (!any || head_q[r].key < kmin)) begin
        any  = 1'b1;
        kmin = head_q[r].key;
      end
    end
    wfnd = 1'b0;
    win  = '0;
    for (int r = 0; r < RUN_COUNT; r++) begin
      eq[r] = head_vld_q[r] && (head_q[r].key == kmin);
      if (eq[r] && (!wfnd || (r == 1 && t0_q < t1_q) || (r == 2 && t1_q < t2_q))) begin
        wfnd = 1'b1;
        win  = 2'(r);
      end
    end
    win_e = head_q[0];
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (win == 2'(r)) begin
        win_e = head_q[r];
      end
    end
  end

  assign emit         = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign freq.upd     = emit && have_cur_q;
  assign freq.more    = more_q;
  assign freq.cur     = cur_q;
  assign freq.nxt_len = la_q.length;

  srcm_mem #(
    .DEPTH(MD)
  ) u_mem (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  srcm_file u_file (
    .clk_i,
    .rst_ni,
    .req_i        (freq),
    .size_limit_i (limit_q),
    .rsp_o        (frsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_req_i.func == FUNC_PULL) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: state_d = fnd ? ST_WAIT : ST_PICK;
      ST_WAIT: state_d = ST_FILL;
      ST_PICK: begin
        if (!any) begin
          state_d = ST_EMIT;
        end else if (win_e.length == '0 || !phase_q) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t0_q        <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      limit_q     <= 31'(SizeLimitRst);
      head_vld_q  <= '0;
      phase_q     <= 1'b0;
      have_cur_q  <= 1'b0;
      more_q      <= 1'b0;
      la_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rsel_q      <= '0;
      for (int r = 0; r < RUN_COUNT; r++) begin
        fill_q[r]   <= '0;
        cursor_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_RUN0_TIME:  t0_q    <= pwdata[30:0];
          REG_RUN1_TIME:  t1_q    <= pwdata[30:0];
          REG_RUN2_TIME:  t2_q    <= pwdata[30:0];
          REG_SIZE_LIMIT: limit_q <= pwdata[30:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        for (int r = 0; r < RUN_COUNT; r++) begin
          if (in_req_i.run_select == 2'(r)) begin
            fill_q[r] <= fill_q[r] + CW'(1);
          end
        end
      end
      if (in_acc && in_req_i.func == FUNC_PULL) begin
        phase_q    <= la_vld_q;
        have_cur_q <= la_vld_q;
        la_vld_q   <= 1'b0;
      end
      if (state_q == ST_FILL && fnd) begin
        rsel_q <= fsel;
      end
      if (state_q == ST_WAIT) begin
        head_vld_q[rsel_q] <= 1'b1;
      end
      if (state_q == ST_PICK) begin
        if (!any) begin
          more_q <= 1'b0;
        end else begin
          for (int r = 0; r < RUN_COUNT; r++) begin
            if (eq[r]) begin
              head_vld_q[r] <= 1'b0;
              cursor_q[r]   <= cursor_q[r] + CW'(1);
            end
          end
          if (win_e.length != '0) begin
            if (!phase_q) begin
              phase_q    <= 1'b1;
              have_cur_q <= 1'b1;
            end else begin
              la_vld_q <= 1'b1;
              more_q   <= 1'b1;
            end
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT) begin
      head_q[rsel_q] <= rd_data;
    end
    if (in_acc && in_req_i.func == FUNC_PULL && la_vld_q) begin
      cur_q <= la_q;
    end
    if (state_q == ST_PICK && any && win_e.length != '0) begin
      if (!phase_q) begin
        cur_q <= win_e;
      end else begin
        la_q <= win_e;
      end
    end
    if (emit) begin
      out_q <= have_cur_q ? frsp : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_entries_only_at_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.end_of_file |-> out_rsp_o.file_entries == '0)
    else $error("file_entries set without end_of_file");
  a_done_closes_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.done_res |-> out_rsp_o.end_of_file)
    else $error("last entry does not close its file");
  a_head_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_q[0] |-> cursor_q[0] < fill_q[0])
    else $error("run head held beyond run fill");
`endif

endmodule
